[rtl/core/smv_pkg.sv]
// Shared types, widths and codes of the sparse binary matrix-vector block.
package smv_pkg;

    localparam int VEC_DEPTH = 4096;
    localparam int ELEM_BITS = 64;
    localparam int ADDR_W    = $clog2(VEC_DEPTH);

    // Fixed field widths of the ports
    localparam int REQ_W  = 2;
    localparam int IDX_W  = 12;
    localparam int VAL_W  = 64;
    localparam int MAT_W  = 16;
    localparam int CNT_W  = 13;
    localparam int STAT_W = 2;
    localparam int CFGI_W = 3;

    // Command queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef logic [ADDR_W-1:0] t_addr;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD  = 2'd0,
        REQ_START = 2'd1,
        REQ_MAT   = 2'd2,
        REQ_READ  = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_START,
        OP_RMW,
        OP_READ
    } t_op;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE  = 2'd1;
    localparam logic [STAT_W-1:0] ST_BEYOND = 2'd2;

    localparam logic [CFGI_W-1:0] CFG_GATHER  = 3'd0;
    localparam logic [CFGI_W-1:0] CFG_ROWS    = 3'd1;
    localparam logic [CFGI_W-1:0] CFG_OUT_LEN = 3'd2;
    localparam logic [CFGI_W-1:0] CFG_SRC_LEN = 3'd3;

    typedef struct packed {
        t_op                  op;
        logic [STAT_W-1:0]    status;
        logic                 done;
        t_addr                dst_addr;
        t_addr                src_addr;
        logic [ELEM_BITS-1:0] value;
    } t_cmd;

    function automatic t_addr to_addr(input logic [31:0] x);
        return t_addr'(x);
    endfunction

endpackage

[rtl/core/smv_in_if.sv]
// Request channel: valid/ready plus request payload.
interface smv_in_if import smv_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [REQ_W-1:0] req_type;
    logic [IDX_W-1:0] elem_index;
    logic [VAL_W-1:0] elem_value;
    logic [MAT_W-1:0] mat_word;

    modport source (output valid, req_type, elem_index, elem_value, mat_word, input ready);
    modport sink   (input valid, req_type, elem_index, elem_value, mat_word, output ready);
endinterface

[rtl/core/smv_out_if.sv]
// Result channel: valid/ready plus result payload.
interface smv_out_if import smv_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [VAL_W-1:0]  read_value;
    logic [STAT_W-1:0] status;
    logic              product_done;

    modport source (output valid, read_value, status, product_done, input ready);
    modport sink   (input valid, read_value, status, product_done, output ready);
endinterface

[rtl/core/smv_cfg_if.sv]
// Configuration write channel: valid/ready plus register index and data.
interface smv_cfg_if import smv_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CFGI_W-1:0] index;
    logic [CNT_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/sparse_binary_matvec_accumulate_top.sv]
// Top level of the sparse binary matrix-vector (GF(2) bit-slice) block.
// Requests enter a parser that tracks rows of the length-prefixed matrix stream,
// checks bounds and turns each request into a command; a four-entry queue feeds
// an executor that owns the source and output memories. Load, start and
// length or rejected words have their response registered when they leave the
// queue; read requests and in-range index words first pass the registered read
// of the vector memories and a wait state, in which an index word's XOR sum is
// written back. A start request clears the output memory one entry a cycle,
// which occupies the executor; after reset the same clearing pass runs before the
// first command executes. Requests keep being accepted while the queue has room,
// and configuration writes are taken at any time.
module sparse_binary_matvec_accumulate_top import smv_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    smv_in_if.sink    i_in,
    smv_cfg_if.sink   i_cfg,
    smv_out_if.source o_out
);
    logic q_full;
    logic q_push;
    t_cmd q_in;
    logic q_pop;
    t_cmd q_head;
    logic q_valid;

    smv_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (i_cfg),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_cmd    (q_in)
    );

    smv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_valid (q_valid)
    );

    smv_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (q_head),
        .i_q_valid (q_valid),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );
endmodule

[rtl/core/smv_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module smv_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/core/smv_queue.sv]
// Short command queue that decouples the front parser from the back executor.
module smv_queue import smv_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_valid
);
    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_count;

    assign o_full  = (r_count == (QPTR_W+1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + (QPTR_W+1)'(i_push) - (QPTR_W+1)'(i_pop);
        end
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end
endmodule

[rtl/core/smv_front.sv]
// Front end: config registers, request classification and matrix stream parser.
module smv_front import smv_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    smv_in_if.sink         i_in,
    smv_cfg_if.sink        i_cfg,
    input  logic           i_q_full,
    output logic           o_push,
    output t_cmd           o_cmd
);
    logic             r_gather;
    logic [CNT_W-1:0] r_row_count;
    logic [CNT_W-1:0] r_out_len;
    logic [CNT_W-1:0] r_src_len;

    logic [CNT_W-1:0] r_row;
    logic [MAT_W-1:0] r_left;
    logic             r_expect;
    logic [CNT_W-1:0] n_row;
    logic [MAT_W-1:0] n_left;
    logic             n_expect;

    logic        idx_in_vec;
    logic [31:0] dst_v;
    logic [31:0] src_v;
    logic        pair_ok;
    t_cmd        cmd;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !i_q_full;
    assign o_push      = i_in.valid && !i_q_full;
    assign o_cmd       = cmd;

    assign idx_in_vec = 32'(i_in.elem_index) < 32'(VEC_DEPTH);
    assign dst_v      = r_gather ? 32'(r_row) : 32'(i_in.mat_word);
    assign src_v      = r_gather ? 32'(i_in.mat_word) : 32'(r_row);
    assign pair_ok    = (src_v < 32'(r_src_len)) && (src_v < 32'(VEC_DEPTH)) &&
                        (dst_v < 32'(r_out_len)) && (dst_v < 32'(VEC_DEPTH));

    always_comb begin
        n_row        = r_row;
        n_left       = r_left;
        n_expect     = r_expect;
        cmd.op       = OP_NOP;
        cmd.status   = ST_OK;
        cmd.dst_addr = to_addr(32'(i_in.elem_index));
        cmd.src_addr = to_addr(32'(i_in.elem_index));
        cmd.value    = i_in.elem_value[ELEM_BITS-1:0];
        unique case (t_req'(i_in.req_type))
            REQ_LOAD: begin
                if (idx_in_vec) begin
                    cmd.op = OP_LOAD;
                end else begin
                    cmd.status = ST_RANGE;
                end
            end
            REQ_START: begin
                cmd.op   = OP_START;
                n_row    = '0;
                n_left   = '0;
                n_expect = 1'b1;
            end
            REQ_MAT: begin
                if (r_row >= r_row_count) begin
                    cmd.status = ST_BEYOND;
                end else if (r_expect) begin
                    n_left   = i_in.mat_word;
                    n_expect = 1'b0;
                    if (i_in.mat_word == '0) begin
                        n_row    = r_row + 1'b1;
                        n_expect = 1'b1;
                    end
                end else begin
                    cmd.dst_addr = to_addr(dst_v);
                    cmd.src_addr = to_addr(src_v);
                    if (pair_ok) begin
                        cmd.op = OP_RMW;
                    end else begin
                        cmd.status = ST_RANGE;
                    end
                    n_left = r_left - 1'b1;
                    if (n_left == '0) begin
                        n_row    = r_row + 1'b1;
                        n_expect = 1'b1;
                    end
                end
            end
            REQ_READ: begin
                if (idx_in_vec && (13'(i_in.elem_index) < r_out_len)) begin
                    cmd.op = OP_READ;
                end else begin
                    cmd.status = ST_RANGE;
                end
            end
            default: ;
        endcase
        cmd.done = (n_row >= r_row_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gather    <= 1'b1;
            r_row_count <= '0;
            r_out_len   <= '0;
            r_src_len   <= '0;
            r_row       <= '0;
            r_left      <= '0;
            r_expect    <= 1'b1;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_GATHER:  r_gather    <= i_cfg.data[0];
                    CFG_ROWS:    r_row_count <= i_cfg.data;
                    CFG_OUT_LEN: r_out_len   <= i_cfg.data;
                    CFG_SRC_LEN: r_src_len   <= i_cfg.data;
                    default: ;
                endcase
            end
            if (o_push) begin
                r_row    <= n_row;
                r_left   <= n_left;
                r_expect <= n_expect;
            end
        end
    end
endmodule

[rtl/core/smv_back.sv]
// Back end: vector memories, XOR read-modify-write, clearing sweep, result register.
module smv_back import smv_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_head,
    input  logic      i_q_valid,
    output logic      o_pop,
    smv_out_if.source o_out
);
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_RUN,
        ST_WAIT
    } t_state;

    t_state            r_state;
    t_addr             r_clr_addr;
    t_cmd              r_cmd;
    logic              r_ovalid;
    logic [VAL_W-1:0]  r_oval;
    logic [STAT_W-1:0] r_ostat;
    logic              r_odone;

    logic                 out_free;
    logic                 finish;
    logic                 direct;
    logic                 src_we;
    logic                 src_re;
    logic [ELEM_BITS-1:0] src_rd;
    logic                 out_we;
    logic                 out_re;
    t_addr                out_waddr;
    logic [ELEM_BITS-1:0] out_wdata;
    logic [ELEM_BITS-1:0] out_rd;

    assign out_free = !r_ovalid || o_out.ready;
    assign o_pop    = (r_state == ST_RUN) && i_q_valid && out_free;
    assign finish   = (r_state == ST_WAIT) && out_free;
    // Commands whose result is known at pop time
    assign direct   = (i_head.op != OP_RMW) && (i_head.op != OP_READ);

    assign src_we = o_pop && (i_head.op == OP_LOAD);
    assign src_re = o_pop && (i_head.op == OP_RMW);
    assign out_re = o_pop && ((i_head.op == OP_RMW) || (i_head.op == OP_READ));
    assign out_we = (r_state == ST_CLEAR) || (finish && (r_cmd.op == OP_RMW));
    assign out_waddr = (r_state == ST_CLEAR) ? r_clr_addr : r_cmd.dst_addr;
    assign out_wdata = (r_state == ST_CLEAR) ? '0 : (out_rd ^ src_rd);

    smv_ram #(.WIDTH(ELEM_BITS), .DEPTH(VEC_DEPTH)) u_src_ram (
        .i_clk   (i_clk),
        .i_we    (src_we),
        .i_waddr (i_head.src_addr),
        .i_wdata (i_head.value),
        .i_re    (src_re),
        .i_raddr (i_head.src_addr),
        .o_rdata (src_rd)
    );

    smv_ram #(.WIDTH(ELEM_BITS), .DEPTH(VEC_DEPTH)) u_out_ram (
        .i_clk   (i_clk),
        .i_we    (out_we),
        .i_waddr (out_waddr),
        .i_wdata (out_wdata),
        .i_re    (out_re),
        .i_raddr (i_head.dst_addr),
        .o_rdata (out_rd)
    );

    assign o_out.valid        = r_ovalid;
    assign o_out.read_value   = r_oval;
    assign o_out.status       = r_ostat;
    assign o_out.product_done = r_odone;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == t_addr'(VEC_DEPTH - 1)) begin
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (o_pop) begin
                        if (i_head.op == OP_START) begin
                            r_state    <= ST_CLEAR;
                            r_clr_addr <= '0;
                        end else if (!direct) begin
                            r_state <= ST_WAIT;
                        end
                    end
                end
                ST_WAIT: begin
                    if (out_free) begin
                        r_state <= ST_RUN;
                    end
                end
                default: r_state <= ST_RUN;
            endcase

            if ((o_pop && direct) || finish) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end

        if (o_pop) begin
            r_cmd <= i_head;
        end
        if (o_pop && direct) begin
            r_oval  <= '0;
            r_ostat <= i_head.status;
            r_odone <= i_head.done;
        end else if (finish) begin
            r_oval  <= (r_cmd.op == OP_READ) ? VAL_W'(out_rd) : '0;
            r_ostat <= r_cmd.status;
            r_odone <= r_cmd.done;
        end
    end

`ifndef SYNTHESIS
    a_pop_only_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_RUN) |-> !o_pop)
        else $error("queue popped outside run state");

    a_wait_is_memory_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WAIT) |-> ((r_cmd.op == OP_RMW) || (r_cmd.op == OP_READ)))
        else $error("wait state holds a command without a memory read");

    a_wait_status_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |-> (r_cmd.status == ST_OK))
        else $error("memory transaction carries an error status");

    a_clear_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && (i_head.op == OP_START)) |=> (r_state == ST_CLEAR && r_clr_addr == '0))
        else $error("start did not begin clearing sweep");
`endif
endmodule

[dv/smv_product_checker.sv]
// Response predictor and comparator for the sparse binary matrix-vector block.
module smv_product_checker import smv_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    smv_in_if    req_ch,
    smv_cfg_if   cfg_ch,
    smv_out_if   rsp_ch,
    output int   o_mismatches,
    output int   o_outstanding,
    output int   o_compared
);

    typedef struct packed {
        logic [VAL_W-1:0]  value;
        logic [STAT_W-1:0] status;
        logic              done;
    } t_rsp;

    // Mirror of the block's vectors, parser and registers
    logic [ELEM_BITS-1:0] src_mem [VEC_DEPTH];
    logic [ELEM_BITS-1:0] out_mem [VEC_DEPTH];
    logic [CNT_W-1:0]     cur_row;
    logic [MAT_W-1:0]     row_left;
    logic                 want_len;
    logic                 gather_m;
    logic [CNT_W-1:0]     n_rows;
    logic [CNT_W-1:0]     n_out;
    logic [CNT_W-1:0]     n_src;

    t_rsp predicted_q[$];
    int   errors;
    int   checked;

    function automatic void rewind_parser();
        cur_row  = '0;
        row_left = '0;
        want_len = 1'b1;
    endfunction

    function automatic void reset_model();
        foreach (src_mem[i]) src_mem[i] = '0;
        foreach (out_mem[i]) out_mem[i] = '0;
        rewind_parser();
        gather_m = 1'b1;
        n_rows   = '0;
        n_out    = '0;
        n_src    = '0;
    endfunction

    function automatic void close_row();
        cur_row  = cur_row + 1'b1;
        want_len = 1'b1;
        row_left = '0;
    endfunction

    // One word of the length-prefixed row stream
    function automatic logic [STAT_W-1:0] consume_word(input logic [MAT_W-1:0] w);
        logic [MAT_W-1:0]  dst;
        logic [MAT_W-1:0]  srci;
        logic [STAT_W-1:0] st;
        st = ST_OK;
        if (cur_row >= n_rows)
            return ST_BEYOND;
        if (want_len) begin
            row_left = w;
            want_len = 1'b0;
            if (w == '0)
                close_row();
            return ST_OK;
        end
        dst  = gather_m ? MAT_W'(cur_row) : w;
        srci = gather_m ? w : MAT_W'(cur_row);
        if (srci < n_src && srci < VEC_DEPTH && dst < n_out && dst < VEC_DEPTH)
            out_mem[dst[ADDR_W-1:0]] = out_mem[dst[ADDR_W-1:0]] ^ src_mem[srci[ADDR_W-1:0]];
        else
            st = ST_RANGE;
        row_left = row_left - 1'b1;
        if (row_left == '0)
            close_row();
        return st;
    endfunction

    function automatic t_rsp predict_rsp(input t_req kind, input logic [IDX_W-1:0] idx,
                                         input logic [VAL_W-1:0] val,
                                         input logic [MAT_W-1:0] w);
        t_rsp r;
        r = '0;
        case (kind)
            REQ_LOAD: src_mem[idx] = val[ELEM_BITS-1:0];
            REQ_START: begin
                foreach (out_mem[i]) out_mem[i] = '0;
                rewind_parser();
            end
            REQ_MAT: r.status = consume_word(w);
            default: begin
                if (idx < n_out)
                    r.value = out_mem[idx];
                else
                    r.status = ST_RANGE;
            end
        endcase
        r.done = (cur_row >= n_rows);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_rsp got;
        t_rsp want;
        if (!i_rst_n) begin
            reset_model();
            predicted_q.delete();
            errors  = 0;
            checked = 0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    CFG_GATHER:  gather_m = cfg_ch.data[0];
                    CFG_ROWS:    n_rows   = cfg_ch.data;
                    CFG_OUT_LEN: n_out    = cfg_ch.data;
                    CFG_SRC_LEN: n_src    = cfg_ch.data;
                    default: ;
                endcase
            end
            // responses are compared before this edge's request is predicted
            if (rsp_ch.valid && rsp_ch.ready) begin
                got.value  = rsp_ch.read_value;
                got.status = rsp_ch.status;
                got.done   = rsp_ch.product_done;
                checked++;
                if (predicted_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("response %0d unexpected: value %h status %0d done %0d",
                                 checked, got.value, got.status, got.done);
                end else begin
                    want = predicted_q.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("mismatch on response %0d: expected value %h status %0d done %0d",
                                     checked, want.value, want.status, want.done);
                            $display("    got value %h status %0d done %0d",
                                     got.value, got.status, got.done);
                        end
                    end
                end
            end
            if (req_ch.valid && req_ch.ready)
                predicted_q.push_back(predict_rsp(t_req'(req_ch.req_type), req_ch.elem_index,
                                                  req_ch.elem_value, req_ch.mat_word));
        end
        o_outstanding <= predicted_q.size();
        o_mismatches  <= errors;
        o_compared    <= checked;
    end

endmodule

[dv/tb.sv]
// Testbench top: reset, request and register stimulus, response backpressure and verdict.
module tb;
    import smv_pkg::*;

    localparam int ITEM_TARGET = 850;
    localparam int IDLE_LIMIT  = 30000;

    logic i_clk;
    logic i_rst_n;

    smv_in_if  req_ch ();
    smv_cfg_if cfg_ch ();
    smv_out_if rsp_ch ();

    int mismatches;
    int outstanding;
    int compared;

    sparse_binary_matvec_accumulate_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .i_cfg   (cfg_ch),
        .o_out   (rsp_ch)
    );

    smv_product_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .req_ch        (req_ch),
        .cfg_ch        (cfg_ch),
        .rsp_ch        (rsp_ch),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_compared    (compared)
    );

    // Register shadow and parser position, used to keep index words legal
    bit gather_cfg = 1'b1;
    int rows_cfg   = 0;
    int outl_cfg   = 0;
    int srcl_cfg   = 0;
    int g_row      = 0;
    int g_left     = 0;
    bit g_want_len = 1'b1;

    bit src_loaded [VEC_DEPTH];
    int loaded_q[$];

    bit calm = 1'b0;
    int sent, mat_sent, starts_sent, cfg_writes, phases;
    int idle_cycles;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // An index word that would read a never-loaded source entry is pushed out of range
    function automatic logic [MAT_W-1:0] fix_index(input logic [MAT_W-1:0] w);
        int dst;
        int srcv;
        if (g_row >= rows_cfg || g_want_len)
            return w;
        dst  = gather_cfg ? g_row : int'(w);
        srcv = gather_cfg ? int'(w) : g_row;
        if (srcv < srcl_cfg && dst < outl_cfg && !src_loaded[srcv]) begin
            if (gather_cfg)
                return MAT_W'(srcl_cfg + $urandom_range(0, 65535 - srcl_cfg));
            return MAT_W'(outl_cfg + $urandom_range(0, 65535 - outl_cfg));
        end
        return w;
    endfunction

    function automatic logic [MAT_W-1:0] index_pick();
        int r;
        r = $urandom_range(0, 99);
        if (gather_cfg) begin
            if (r < 70 && loaded_q.size() > 0)
                return MAT_W'(loaded_q[$urandom_range(0, loaded_q.size() - 1)]);
            if (r < 85)
                return MAT_W'($urandom_range(0, 4200));
            return MAT_W'($urandom);
        end
        if (r < 80 && outl_cfg > 0)
            return MAT_W'($urandom_range(0, outl_cfg - 1));
        return MAT_W'($urandom);
    endfunction

    function automatic logic [IDX_W-1:0] read_pick();
        if (outl_cfg > 0 && $urandom_range(0, 4) != 0)
            return IDX_W'($urandom_range(0, outl_cfg - 1));
        return IDX_W'($urandom);
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 0;
        if (r < 25) return VEC_DEPTH;
        if (r < 35) return $urandom_range(0, VEC_DEPTH);
        return $urandom_range(1, 16);
    endfunction

    function automatic int pick_rows();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)  return 0;
        if (r < 18) return VEC_DEPTH;
        if (r < 28) return $urandom_range(0, VEC_DEPTH);
        return $urandom_range(1, 8);
    endfunction

    task automatic send_req(input t_req kind, input logic [IDX_W-1:0] idx,
                            input logic [VAL_W-1:0] val, input logic [MAT_W-1:0] w);
        int gap;
        logic [MAT_W-1:0] wf;
        wf  = (kind == REQ_MAT) ? fix_index(w) : w;
        gap = calm ? 0 : gap_len();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= kind;
        req_ch.elem_index <= idx;
        req_ch.elem_value <= val;
        req_ch.mat_word   <= wf;
        do @(posedge i_clk); while (!req_ch.ready);
        sent++;
        case (kind)
            REQ_LOAD: begin
                if (!src_loaded[idx]) begin
                    src_loaded[idx] = 1'b1;
                    loaded_q.push_back(int'(idx));
                end
            end
            REQ_START: begin
                starts_sent++;
                g_row      = 0;
                g_left     = 0;
                g_want_len = 1'b1;
            end
            REQ_MAT: begin
                mat_sent++;
                if (g_row < rows_cfg) begin
                    if (g_want_len) begin
                        g_left     = int'(wf);
                        g_want_len = 1'b0;
                    end else begin
                        g_left--;
                    end
                    if (g_left == 0) begin
                        g_row++;
                        g_want_len = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic write_reg(input logic [CFGI_W-1:0] idx, input logic [CNT_W-1:0] data);
        int gap;
        gap = calm ? 0 : gap_len();
        if (gap > 0) begin
            cfg_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_writes++;
        case (idx)
            CFG_GATHER:  gather_cfg = data[0];
            CFG_ROWS:    rows_cfg   = int'(data);
            CFG_OUT_LEN: outl_cfg   = int'(data);
            CFG_SRC_LEN: srcl_cfg   = int'(data);
            default: ;
        endcase
    endtask

    // Stop issuing requests and wait for every response to come back
    task automatic settle();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    task automatic configure(input bit g, input int rows, input int outl, input int srcl);
        logic [CFGI_W-1:0] regs [4];
        logic [CNT_W-1:0]  vals [4];
        int first;
        regs  = '{CFG_GATHER, CFG_ROWS, CFG_OUT_LEN, CFG_SRC_LEN};
        vals  = '{CNT_W'(g), CNT_W'(rows), CNT_W'(outl), CNT_W'(srcl)};
        first = $urandom_range(0, 3);
        settle();
        for (int k = 0; k < 4; k++)
            write_reg(regs[(first + k) % 4], vals[(first + k) % 4]);
        cfg_ch.valid <= 1'b0;
        phases++;
    endtask

    task automatic run_phase(input int budget);
        int n;
        int r;
        logic [MAT_W-1:0] w;
        calm = ($urandom_range(0, 4) == 0);
        configure(1'($urandom_range(0, 1)), pick_rows(), pick_len(), pick_len());
        if ($urandom_range(0, 99) < 80) begin
            // well-formed product: loads, start, rows, then read-back
            repeat ($urandom_range(1, 6))
                send_req(REQ_LOAD, ($urandom_range(0, 9) < 8) ? IDX_W'($urandom_range(0, 15))
                                                              : IDX_W'($urandom),
                         rand64(), MAT_W'($urandom));
            send_req(REQ_START, IDX_W'($urandom), rand64(), MAT_W'($urandom));
            n = 0;
            while (n < budget && g_row < rows_cfg) begin
                r = $urandom_range(0, 99);
                if (r < 5) begin
                    send_req(REQ_READ, read_pick(), rand64(), MAT_W'($urandom));
                end else if (r < 9) begin
                    send_req(REQ_LOAD, IDX_W'($urandom_range(0, 31)), rand64(), MAT_W'($urandom));
                end else begin
                    if (g_want_len) begin
                        r = $urandom_range(0, 99);
                        w = (r < 15) ? '0 : (r < 90) ? MAT_W'($urandom_range(1, 4))
                                                     : MAT_W'($urandom_range(5, 12));
                    end else begin
                        w = index_pick();
                    end
                    send_req(REQ_MAT, IDX_W'($urandom), rand64(), w);
                end
                n++;
            end
            if (g_row >= rows_cfg && $urandom_range(0, 1) == 1)
                send_req(REQ_MAT, IDX_W'($urandom), rand64(), MAT_W'($urandom));
            repeat ($urandom_range(2, 6))
                send_req(REQ_READ, read_pick(), rand64(), MAT_W'($urandom));
        end else begin
            // noise and broken streams
            repeat (budget) begin
                r = $urandom_range(0, 99);
                if (r < 30)
                    send_req(REQ_LOAD, IDX_W'($urandom), rand64(), MAT_W'($urandom));
                else if (r < 34)
                    send_req(REQ_START, IDX_W'($urandom), rand64(), MAT_W'($urandom));
                else if (r < 74)
                    send_req(REQ_MAT, IDX_W'($urandom), rand64(),
                             ($urandom_range(0, 1) == 1) ? MAT_W'($urandom_range(0, 15))
                                                         : MAT_W'($urandom));
                else
                    send_req(REQ_READ, read_pick(), rand64(), MAT_W'($urandom));
            end
        end
    endtask

    // Response backpressure: runs of ready, mostly short stalls, a few long ones
    initial begin
        int stall;
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            rsp_ch.ready <= 1'b1;
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(50, 300)
                                                : $urandom_range(1, 12)) @(posedge i_clk);
            stall = gap_len();
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles, %0d responses pending",
                         idle_cycles, outstanding);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n           <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.req_type   <= REQ_LOAD;
        req_ch.elem_index <= '0;
        req_ch.elem_value <= '0;
        req_ch.mat_word   <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= CFG_GATHER;
        cfg_ch.data       <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset registers: empty vectors, no rows
        send_req(REQ_READ, '0, rand64(), MAT_W'($urandom));
        send_req(REQ_MAT, IDX_W'($urandom), rand64(), MAT_W'(5));
        send_req(REQ_LOAD, IDX_W'(VEC_DEPTH - 1), '1, MAT_W'($urandom));
        send_req(REQ_LOAD, '0, '0, MAT_W'($urandom));
        send_req(REQ_LOAD, IDX_W'(1), rand64(), MAT_W'($urandom));
        send_req(REQ_LOAD, IDX_W'(2), rand64(), MAT_W'($urandom));

        // gather over full-size vectors; stream begins before any start
        configure(1'b1, 4, VEC_DEPTH, VEC_DEPTH);
        send_req(REQ_MAT, '0, '0, MAT_W'(2));
        send_req(REQ_MAT, '0, '0, MAT_W'(VEC_DEPTH - 1));
        send_req(REQ_MAT, '0, '0, '0);
        send_req(REQ_MAT, '0, '0, '0);                 // empty row
        send_req(REQ_MAT, '0, '0, MAT_W'(1));
        send_req(REQ_MAT, '0, '0, '1);                 // index far out of range
        send_req(REQ_MAT, '0, '0, MAT_W'(1));
        send_req(REQ_MAT, '0, '0, MAT_W'(VEC_DEPTH));  // index just past the bound
        send_req(REQ_MAT, '1, '1, MAT_W'(7));          // past the last row
        send_req(REQ_READ, '0, rand64(), '0);
        send_req(REQ_READ, '1, rand64(), '0);
        send_req(REQ_START, '0, rand64(), '0);
        send_req(REQ_READ, '0, rand64(), '0);

        // scatter with one output and one source element
        configure(1'b0, 2, 1, 1);
        send_req(REQ_START, '1, rand64(), '1);
        send_req(REQ_MAT, '0, '0, MAT_W'(2));
        send_req(REQ_MAT, '0, '0, '0);
        send_req(REQ_MAT, '0, '0, MAT_W'(1));          // output index past out_length
        send_req(REQ_MAT, '0, '0, MAT_W'(1));
        send_req(REQ_MAT, '0, '0, '0);                 // row 1 past src_length
        send_req(REQ_READ, '0, rand64(), '0);
        send_req(REQ_READ, IDX_W'(1), rand64(), '0);

        while (sent < ITEM_TARGET)
            run_phase($urandom_range(20, 45));

        settle();
        repeat (12) @(posedge i_clk);
        $display("covered %0d requests: %0d matrix words, %0d product starts, %0d settings",
                 sent, mat_sent, starts_sent, phases);
        $display("%0d register writes, %0d responses compared, %0d mismatches",
                 cfg_writes, compared, mismatches);
        if (mismatches == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/smv_pkg.sv
rtl/core/smv_in_if.sv
rtl/core/smv_out_if.sv
rtl/core/smv_cfg_if.sv
rtl/core/smv_ram.sv
rtl/core/smv_queue.sv
rtl/core/smv_front.sv
rtl/core/smv_back.sv
rtl/core/sparse_binary_matvec_accumulate_top.sv
dv/smv_product_checker.sv
dv/tb.sv
